[rtl/rvc_exp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rvc_exp_pkg
// Types and opcode constants shared by the compressed instruction expander.
// ----------------------------------------------------------------------------
package rvc_exp_pkg;

    typedef logic [15:0] t_half_instr;
    typedef logic [31:0] t_full_instr;

    typedef struct packed {
        t_full_instr full_instr;
        logic        illegal;
    } t_expand_result;

    // quadrants
    localparam logic [1:0] QUAD_0 = 2'b00;
    localparam logic [1:0] QUAD_1 = 2'b01;
    localparam logic [1:0] QUAD_2 = 2'b10;
    localparam logic [1:0] QUAD_3 = 2'b11;

    // compressed funct3 per quadrant
    localparam logic [2:0] C0_ADDI4SPN = 3'd0;
    localparam logic [2:0] C0_LW       = 3'd2;
    localparam logic [2:0] C0_SW       = 3'd6;
    localparam logic [2:0] C1_ADDI     = 3'd0;
    localparam logic [2:0] C1_JAL      = 3'd1;
    localparam logic [2:0] C1_LI       = 3'd2;
    localparam logic [2:0] C1_LUI      = 3'd3;
    localparam logic [2:0] C1_ALU      = 3'd4;
    localparam logic [2:0] C1_J        = 3'd5;
    localparam logic [2:0] C1_BEQZ     = 3'd6;
    localparam logic [2:0] C1_BNEZ     = 3'd7;
    localparam logic [2:0] C2_SLLI     = 3'd0;
    localparam logic [2:0] C2_LWSP     = 3'd2;
    localparam logic [2:0] C2_JR       = 3'd4;
    localparam logic [2:0] C2_SWSP     = 3'd6;

    // quadrant 1 alu sub-ops, bits 11:10 and 6:5
    localparam logic [1:0] ALU_SRLI = 2'd0;
    localparam logic [1:0] ALU_SRAI = 2'd1;
    localparam logic [1:0] ALU_ANDI = 2'd2;
    localparam logic [1:0] RR_SUB   = 2'd0;
    localparam logic [1:0] RR_XOR   = 2'd1;
    localparam logic [1:0] RR_OR    = 2'd2;

    // base opcodes
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;

    localparam t_full_instr EBREAK_WORD = 32'h0010_0073;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_WORD = 3'b010;
    localparam logic [2:0] F3_XOR  = 3'b100;
    localparam logic [2:0] F3_SR   = 3'b101;
    localparam logic [2:0] F3_OR   = 3'b110;
    localparam logic [2:0] F3_AND  = 3'b111;

    localparam logic [6:0] F7_SUB  = 7'h20;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

endpackage : rvc_exp_pkg
`default_nettype wire

[rtl/rvc_exp_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rvc_exp_decode
// Combinational rewrite of one 16-bit compressed word into its 32-bit form.
// ----------------------------------------------------------------------------
module rvc_exp_decode (
    input  rvc_exp_pkg::t_half_instr    i_half_instr,
    output rvc_exp_pkg::t_expand_result o_result
);
    import rvc_exp_pkg::*;

    t_half_instr x;
    logic [2:0]  f3;
    logic [4:0]  rhi;
    logic [4:0]  rlo;
    logic [4:0]  rp7;
    logic [4:0]  rp2;
    logic        b12;
    logic [11:0] imm6;
    logic [9:0]  addi4_imm;
    logic [6:0]  lw_imm;
    logic [11:0] sp16_imm;
    logic [20:1] j_off;
    logic [12:1] b_off;
    logic [7:0]  lwsp_imm;
    logic [7:0]  swsp_imm;
    logic [31:0] j_word;
    logic [31:0] full;
    logic        bad;

    assign x   = i_half_instr;
    assign f3  = x[15:13];
    assign rhi = x[11:7];
    assign rlo = x[6:2];
    assign rp7 = {2'b01, x[9:7]};
    assign rp2 = {2'b01, x[4:2]};
    assign b12 = x[12];

    assign imm6      = {{7{x[12]}}, x[6:2]};
    assign addi4_imm = {x[10:7], x[12:11], x[5], x[6], 2'b00};
    assign lw_imm    = {x[5], x[12:10], x[6], 2'b00};
    assign sp16_imm  = {{3{x[12]}}, x[4:3], x[5], x[2], x[6], 4'b0000};
    assign j_off     = {{10{x[12]}}, x[8], x[10:9], x[6], x[7], x[2], x[11], x[5:3]};
    assign b_off     = {{5{x[12]}}, x[6:5], x[2], x[11:10], x[4:3]};
    assign lwsp_imm  = {x[3:2], x[12], x[6:4], 2'b00};
    assign swsp_imm  = {x[8:7], x[12:9], 2'b00};

    // jump word without rd; rd is or-ed in per form
    assign j_word = {j_off[20], j_off[10:1], j_off[11], j_off[19:12], 5'd0, OPC_JAL};

    always_comb begin
        full = '0;
        bad  = 1'b0;
        unique case (x[1:0])
            QUAD_0: begin
                unique case (f3)
                    C0_ADDI4SPN: begin
                        if (addi4_imm == '0) begin
                            bad = 1'b1;
                        end else begin
                            full = {2'b00, addi4_imm, REG_SP, F3_ADD, rp2, OPC_OPIMM};
                        end
                    end
                    C0_LW: full = {5'd0, lw_imm, rp7, F3_WORD, rp2, OPC_LOAD};
                    C0_SW: full = {5'd0, lw_imm[6:5], rp2, rp7, F3_WORD, lw_imm[4:0], OPC_STORE};
                    default: bad = 1'b1;
                endcase
            end
            QUAD_1: begin
                unique case (f3)
                    C1_ADDI: full = {imm6, rhi, F3_ADD, rhi, OPC_OPIMM};
                    C1_JAL:  full = j_word | {20'd0, REG_RA, 7'd0};
                    C1_LI: begin
                        if (rhi == REG_ZERO) begin
                            bad = 1'b1;
                        end else begin
                            full = {imm6, REG_ZERO, F3_ADD, rhi, OPC_OPIMM};
                        end
                    end
                    C1_LUI: begin
                        if (rhi == REG_SP) begin
                            if (sp16_imm == '0) begin
                                bad = 1'b1;
                            end else begin
                                full = {sp16_imm, REG_SP, F3_ADD, REG_SP, OPC_OPIMM};
                            end
                        end else if (rhi == REG_ZERO || (!b12 && rlo == 5'd0)) begin
                            bad = 1'b1;
                        end else begin
                            full = {{14{x[12]}}, x[12], x[6:2], rhi, OPC_LUI};
                        end
                    end
                    C1_ALU: begin
                        unique case (x[11:10]) inside
                            ALU_SRLI, ALU_SRAI: begin
                                if (b12) begin
                                    bad = 1'b1;
                                end else begin
                                    full = {1'b0, x[10], 5'd0, rlo, rp7, F3_SR, rp7,
                                            OPC_OPIMM};
                                end
                            end
                            ALU_ANDI: full = {imm6, rp7, F3_AND, rp7, OPC_OPIMM};
                            default: begin
                                if (b12) begin
                                    bad = 1'b1;
                                end else begin
                                    unique case (x[6:5])
                                        RR_SUB: full = {F7_SUB, rp2, rp7, F3_ADD, rp7, OPC_OP};
                                        RR_XOR: full = {7'd0, rp2, rp7, F3_XOR, rp7, OPC_OP};
                                        RR_OR:  full = {7'd0, rp2, rp7, F3_OR, rp7, OPC_OP};
                                        default: full = {7'd0, rp2, rp7, F3_AND, rp7, OPC_OP};
                                    endcase
                                end
                            end
                        endcase
                    end
                    C1_J: full = j_word;
                    default: begin
                        // beqz / bnez
                        full = {b_off[12], b_off[10:5], REG_ZERO, rp7, 2'b00, x[13],
                                b_off[4:1], b_off[11], OPC_BRANCH};
                    end
                endcase
            end
            QUAD_2: begin
                unique case (f3)
                    C2_SLLI: begin
                        if (b12) begin
                            bad = 1'b1;
                        end else begin
                            full = {7'd0, rlo, rhi, F3_SLL, rhi, OPC_OPIMM};
                        end
                    end
                    C2_LWSP: begin
                        if (rhi == REG_ZERO) begin
                            bad = 1'b1;
                        end else begin
                            full = {4'd0, lwsp_imm, REG_SP, F3_WORD, rhi, OPC_LOAD};
                        end
                    end
                    C2_JR: begin
                        if (!b12) begin
                            if (rlo == REG_ZERO) begin
                                if (rhi == REG_ZERO) begin
                                    bad = 1'b1;
                                end else begin
                                    full = {12'd0, rhi, F3_ADD, REG_ZERO, OPC_JALR};
                                end
                            end else begin
                                full = {7'd0, rlo, REG_ZERO, F3_ADD, rhi, OPC_OP};
                            end
                        end else if (rhi == REG_ZERO && rlo == REG_ZERO) begin
                            full = EBREAK_WORD;
                        end else if (rhi == REG_ZERO) begin
                            bad = 1'b1;
                        end else if (rlo == REG_ZERO) begin
                            full = {12'd0, rhi, F3_ADD, REG_RA, OPC_JALR};
                        end else begin
                            full = {7'd0, rlo, rhi, F3_ADD, rhi, OPC_OP};
                        end
                    end
                    C2_SWSP: full = {4'd0, swsp_imm[7:5], rlo, REG_SP, F3_WORD, swsp_imm[4:0],
                                     OPC_STORE};
                    default: bad = 1'b1;
                endcase
            end
            default: bad = 1'b1;
        endcase
    end

    assign o_result.full_instr = full;
    assign o_result.illegal    = bad;

endmodule : rvc_exp_decode
`default_nettype wire

[rtl/rvc_instruction_expander_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rvc_instruction_expander_core
// RV32C to RV32I instruction expander, one word per cycle.
// ----------------------------------------------------------------------------
// usage:
//   drive i_half_instr and raise start; the word is taken at any rising edge
//   with start high, as busy is tied low and a word can enter every cycle.
//   the word is captured in an input register, rewritten by the decode logic
//   and captured again in the result register.
//   o_strobe is high for one cycle with o_full_instr and o_illegal; the
//   strobe rises at the edge after the word was taken, and throughput is
//   1 word per cycle, set by the input and result registers.
//   illegal or reserved encodings, and words with low bits 11, give
//   o_full_instr zero and o_illegal high.
//   the receiver cannot stall: each result is shown for exactly one cycle.
//   synchronous reset drops both valid flags, so nothing in flight at reset
//   is delivered.
// ----------------------------------------------------------------------------
module rvc_instruction_expander_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  rvc_exp_pkg::t_half_instr i_half_instr,
    output logic                     o_strobe,
    output rvc_exp_pkg::t_full_instr o_full_instr,
    output logic                     o_illegal
);
    import rvc_exp_pkg::*;

    logic           r_in_valid;
    logic           n_in_valid;
    t_half_instr    r_half;
    logic           r_out_valid;
    t_full_instr    r_full;
    logic           r_illegal;
    t_expand_result dec_result;

    assign busy       = 1'b0;
    assign n_in_valid = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_valid) begin
            r_half <= i_half_instr;
        end
        if (r_in_valid) begin
            r_full    <= dec_result.full_instr;
            r_illegal <= dec_result.illegal;
        end
    end

    rvc_exp_decode u_decode (
        .i_half_instr (r_half),
        .o_result     (dec_result)
    );

    assign o_strobe     = r_out_valid;
    assign o_full_instr = r_full;
    assign o_illegal    = r_illegal;

    // every taken word produces a result strobe after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("taken word did not produce a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_in_valid))
        else $error("result strobe without a word in the input stage");

    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_illegal) |-> (o_full_instr == '0))
        else $error("illegal result with non-zero expansion");

    a_legal_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_illegal) |-> (o_full_instr[1:0] == QUAD_3))
        else $error("legal expansion is not a 32-bit encoding");

endmodule : rvc_instruction_expander_core
`default_nettype wire

[tb/sv/rvc_instruction_expander_core_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rvc_instruction_expander_core_tb
// Self-checking bench for the RV32C to RV32I expander. A short directed table
// hits the quadrant corners, the reserved and zero-field encodings and most
// compressed opcodes. It is followed by biased random words with uneven send
// gaps. Every expanded word is checked, in order, against its table entry or
// a local expansion model.
// ----------------------------------------------------------------------------
module rvc_instruction_expander_core_tb;

    import rvc_exp_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 8;
    localparam int N_RANDOM    = 750;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [2:0] F3_BEQ = 3'b000;
    localparam logic [2:0] F3_BNE = 3'b001;

    typedef struct packed {
        t_half_instr word;
        logic        known;
        t_full_instr full_instr;
        logic        illegal;
    } t_dir_row;

    typedef struct {
        t_half_instr    word;
        t_expand_result res;
    } t_pending_exp;

    localparam int N_DIR = 30;

    t_dir_row dir_rows [N_DIR] = '{
        '{16'h0000, 1'b1, 32'h0, 1'b1},         // all zero, addi4spn with zero imm
        '{16'hFFFF, 1'b1, 32'h0, 1'b1},         // quadrant three, not compressed
        '{16'h0001, 1'b1, 32'h0000_0013, 1'b0}, // c.nop
        '{16'h9002, 1'b1, 32'h0010_0073, 1'b0}, // ebreak
        '{16'h2000, 1'b1, 32'h0, 1'b1},         // c.fld slot
        '{16'hFFFC, 1'b1, 32'h0, 1'b1},         // c.fsw slot
        '{16'h8000, 1'b1, 32'h0, 1'b1},         // reserved quadrant 0 slot
        '{16'h2002, 1'b1, 32'h0, 1'b1},         // c.fldsp slot
        '{16'h8002, 1'b1, 32'h0, 1'b1},         // c.jr with rs1 x0
        '{16'h4001, 1'b1, 32'h0, 1'b1},         // c.li to x0
        '{16'h6101, 1'b1, 32'h0, 1'b1},         // c.addi16sp zero imm
        '{16'h6081, 1'b1, 32'h0, 1'b1},         // c.lui zero imm
        '{16'h1006, 1'b1, 32'h0, 1'b1},         // c.slli wide shamt
        '{16'h9001, 1'b1, 32'h0, 1'b1},         // c.srli wide shamt
        '{16'h9C01, 1'b1, 32'h0, 1'b1},         // reg-reg with bit 12 set
        '{16'h4002, 1'b1, 32'h0, 1'b1},         // c.lwsp to x0
        '{16'h9006, 1'b1, 32'h0, 1'b1},         // c.add to x0
        '{16'h1FFC, 1'b0, 32'h0, 1'b0},         // addi4spn, largest imm
        '{16'h5FFC, 1'b0, 32'h0, 1'b0},         // c.lw
        '{16'hDFFC, 1'b0, 32'h0, 1'b0},         // c.sw
        '{16'h3FFD, 1'b0, 32'h0, 1'b0},         // c.jal, offset -2
        '{16'hA001, 1'b0, 32'h0, 1'b0},         // c.j, offset 0
        '{16'hDFFD, 1'b0, 32'h0, 1'b0},         // c.beqz
        '{16'h7FFD, 1'b0, 32'h0, 1'b0},         // c.lui x31, -1
        '{16'h847D, 1'b0, 32'h0, 1'b0},         // c.srai
        '{16'h8C5D, 1'b0, 32'h0, 1'b0},         // c.or
        '{16'h8FFE, 1'b0, 32'h0, 1'b0},         // c.mv x31, x31
        '{16'h9F82, 1'b0, 32'h0, 1'b0},         // c.jalr x31
        '{16'h5FFE, 1'b0, 32'h0, 1'b0},         // c.lwsp, largest offset
        '{16'hFFFE, 1'b0, 32'h0, 1'b0}          // c.fswsp slot
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_half_instr i_half_instr;
    logic        o_strobe;
    t_full_instr o_full_instr;
    logic        o_illegal;

    t_pending_exp pending_expansions [$];
    int           n_words   = 0;
    int           n_checked = 0;
    int           n_illegal = 0;
    int           n_errors  = 0;
    int           n_cycles  = 0;

    rvc_instruction_expander_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_half_instr (i_half_instr),
        .o_strobe     (o_strobe),
        .o_full_instr (o_full_instr),
        .o_illegal    (o_illegal)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_full_instr enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic t_full_instr enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OPC_STORE};
    endfunction

    function automatic t_full_instr enc_jal(t_half_instr h, logic [4:0] rd);
        logic [20:0] off;
        off = {{9{h[12]}}, h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
        return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

    function automatic t_expand_result expand_rvc(t_half_instr h);
        t_full_instr    w;
        logic [31:0]    v;
        logic [11:0]    imm;
        logic [12:0]    boff;
        logic [4:0]     rhi;
        logic [4:0]     rlo;
        logic [4:0]     rp7;
        logic [4:0]     rp2;
        logic [6:0]     f7;
        logic [2:0]     f3;
        t_expand_result r;
        rhi = h[11:7];
        rlo = h[6:2];
        rp7 = {2'b01, h[9:7]};
        rp2 = {2'b01, h[4:2]};
        v   = {{26{h[12]}}, h[12], h[6:2]};
        w   = '0;
        case (h[1:0])
            QUAD_0: begin
                case (h[15:13])
                    C0_ADDI4SPN: begin
                        imm = {2'b00, h[10:7], h[12:11], h[5], h[6], 2'b00};
                        if (imm != '0) w = enc_i(imm, REG_SP, F3_ADD, rp2, OPC_OPIMM);
                    end
                    C0_LW: begin
                        imm = {5'b0, h[5], h[12:10], h[6], 2'b00};
                        w = enc_i(imm, rp7, F3_WORD, rp2, OPC_LOAD);
                    end
                    C0_SW: begin
                        imm = {5'b0, h[5], h[12:10], h[6], 2'b00};
                        w = enc_s(imm, rp2, rp7);
                    end
                    default: w = '0;
                endcase
            end
            QUAD_1: begin
                case (h[15:13])
                    C1_ADDI: w = enc_i(v[11:0], rhi, F3_ADD, rhi, OPC_OPIMM);
                    C1_JAL:  w = enc_jal(h, REG_RA);
                    C1_LI: begin
                        if (rhi != REG_ZERO) w = enc_i(v[11:0], REG_ZERO, F3_ADD, rhi, OPC_OPIMM);
                    end
                    C1_LUI: begin
                        if (rhi == REG_SP) begin
                            // addi16sp, imm in units of 16
                            imm = {{3{h[12]}}, h[4:3], h[5], h[2], h[6], 4'b0000};
                            if (imm != '0) w = enc_i(imm, REG_SP, F3_ADD, REG_SP, OPC_OPIMM);
                        end else if (rhi != REG_ZERO && v != '0) begin
                            w = {v[19:0], rhi, OPC_LUI};
                        end
                    end
                    C1_ALU: begin
                        case (h[11:10])
                            ALU_SRLI, ALU_SRAI: begin
                                if (!h[12]) begin
                                    imm = {1'b0, h[11:10] == ALU_SRAI, 5'b0, rlo};
                                    w = enc_i(imm, rp7, F3_SR, rp7, OPC_OPIMM);
                                end
                            end
                            ALU_ANDI: w = enc_i(v[11:0], rp7, F3_AND, rp7, OPC_OPIMM);
                            default: begin
                                if (!h[12]) begin
                                    f7 = (h[6:5] == RR_SUB) ? F7_SUB : 7'h00;
                                    case (h[6:5])
                                        RR_SUB:  f3 = F3_ADD;
                                        RR_XOR:  f3 = F3_XOR;
                                        RR_OR:   f3 = F3_OR;
                                        default: f3 = F3_AND;
                                    endcase
                                    w = {f7, rp2, rp7, f3, rp7, OPC_OP};
                                end
                            end
                        endcase
                    end
                    C1_J: w = enc_jal(h, REG_ZERO);
                    default: begin
                        boff = {{4{h[12]}}, h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0};
                        f3 = (h[15:13] == C1_BEQZ) ? F3_BEQ : F3_BNE;
                        w = {boff[12], boff[10:5], REG_ZERO, rp7, f3, boff[4:1], boff[11],
                             OPC_BRANCH};
                    end
                endcase
            end
            QUAD_2: begin
                case (h[15:13])
                    C2_SLLI: begin
                        if (!h[12]) w = enc_i({7'b0, rlo}, rhi, F3_SLL, rhi, OPC_OPIMM);
                    end
                    C2_LWSP: begin
                        imm = {4'b0, h[3:2], h[12], h[6:4], 2'b00};
                        if (rhi != REG_ZERO) w = enc_i(imm, REG_SP, F3_WORD, rhi, OPC_LOAD);
                    end
                    C2_JR: begin
                        if (!h[12]) begin
                            if (rlo != REG_ZERO) begin
                                w = {7'h00, rlo, REG_ZERO, F3_ADD, rhi, OPC_OP};
                            end else if (rhi != REG_ZERO) begin
                                w = enc_i(12'h000, rhi, F3_ADD, REG_ZERO, OPC_JALR);
                            end
                        end else if (rhi == REG_ZERO) begin
                            if (rlo == REG_ZERO) w = EBREAK_WORD;
                        end else if (rlo == REG_ZERO) begin
                            w = enc_i(12'h000, rhi, F3_ADD, REG_RA, OPC_JALR);
                        end else begin
                            w = {7'h00, rlo, rhi, F3_ADD, rhi, OPC_OP};
                        end
                    end
                    C2_SWSP: w = enc_s({4'b0, h[8:7], h[12:9], 2'b00}, rlo, REG_SP);
                    default: w = '0;
                endcase
            end
            default: w = '0;
        endcase
        r.full_instr = w;
        r.illegal    = (w == '0);
        return r;
    endfunction

    // mostly no gap, some short ones, a few long
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input t_half_instr word, input t_expand_result want);
        t_pending_exp p;
        start        <= 1'b1;
        i_half_instr <= word;
        do @(posedge i_clk); while (busy);
        p.word = word;
        p.res  = want;
        pending_expansions.push_back(p);
        n_words++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // results are taken at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        t_pending_exp p;
        if (i_rst_n && o_strobe) begin
            if (pending_expansions.size() == 0) begin
                $display("%0t: result with nothing pending: full_instr=%h illegal=%b",
                         $time, o_full_instr, o_illegal);
                n_errors++;
            end else begin
                p = pending_expansions.pop_front();
                n_checked++;
                if (o_illegal) n_illegal++;
                if (o_full_instr !== p.res.full_instr) begin
                    $display("%0t: word %h full_instr expected %h actual %h",
                             $time, p.word, p.res.full_instr, o_full_instr);
                    n_errors++;
                end
                if (o_illegal !== p.res.illegal) begin
                    $display("%0t: word %h illegal expected %b actual %b",
                             $time, p.word, p.res.illegal, o_illegal);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_expansions.size());
            $display("rvc_instruction_expander_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_expand_result want;
        t_half_instr    word;
        int             gap;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_half_instr = '0;
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].known) begin
                want.full_instr = dir_rows[k].full_instr;
                want.illegal    = dir_rows[k].illegal;
            end else begin
                want = expand_rvc(dir_rows[k].word);
            end
            send_word(dir_rows[k].word, want);
            gap = random_gap();
            if (gap > 0) hold_off(gap);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            word = t_half_instr'($urandom);
            // push some words onto the zero-field and legal-quadrant cases
            case ($urandom_range(0, 7))
                0: word[11:7] = REG_ZERO;
                1: word[6:2]  = 5'd0;
                2: word[12]   = 1'b0;
                3: word[1:0]  = QUAD_2;
                4: word[1:0]  = QUAD_1;
                5: word[1:0]  = QUAD_0;
                default: ;
            endcase
            send_word(word, expand_rvc(word));
            if (k == N_RANDOM / 2) begin
                // sender waits for every pending word to come back
                hold_off(1);
                while (pending_expansions.size() != 0) @(posedge i_clk);
            end else if ((k / 100) % 3 != 2) begin
                gap = random_gap();
                if (gap > 0) hold_off(gap);
            end
        end

        hold_off(1);
        while (pending_expansions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d compressed words (%0d directed), checked %0d expansions, %0d illegal",
                 n_words, N_DIR, n_checked, n_illegal);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0) begin
            $display("rvc_instruction_expander_core_tb: done, clean");
        end else begin
            $display("rvc_instruction_expander_core_tb: done, errors");
        end
        $finish;
    end

endmodule : rvc_instruction_expander_core_tb
`default_nettype wire

[filelist.f]
rtl/rvc_exp_pkg.sv
rtl/rvc_exp_decode.sv
rtl/rvc_instruction_expander_core.sv
tb/sv/rvc_instruction_expander_core_tb.sv
